### rtl/core/lct_pkg.sv
package lct_pkg;

   // Fixed field widths
   localparam int SLOT_BITS       = 6;
   localparam int COORD_PORT_BITS = 16;
   localparam int HIST_BITS       = 8;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;
   localparam int FILTER_BITS     = 2;
   localparam int LIMIT_BITS      = 11;

   // Minimum history length for a track to count as ready
   localparam logic [HIST_BITS-1:0] HIST_MIN = 8'd2;

   // Item actions
   localparam logic ACT_EVAL  = 1'b0;
   localparam logic ACT_CLEAR = 1'b1;

   // Crossing directions
   localparam logic DIR_IN  = 1'b0;
   localparam logic DIR_OUT = 1'b1;

   // Direction filter codes
   localparam logic [FILTER_BITS-1:0] FILTER_BOTH = 2'd0;
   localparam logic [FILTER_BITS-1:0] FILTER_IN   = 2'd1;
   localparam logic [FILTER_BITS-1:0] FILTER_OUT  = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_ENABLE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_START_X = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_START_Y = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_END_X   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_END_Y   = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIR_FILTER   = 3'd5;

   // Controller states
   typedef enum logic [2:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_SIGN,
      ST_DONE
   } ctrl_state_type;

   // Which orientation the multiplier pair works on
   // (line A->B or motion P->Q, against a third point)
   typedef enum logic [1:0] {
      ORI_AB_P,
      ORI_AB_Q,
      ORI_PQ_A,
      ORI_PQ_B
   } orient_sel_type;

   // Controller to datapath commands
   typedef struct packed {
      logic           sweep;
      logic           load;
      logic           mul_en;
      orient_sel_type mul_sel;
      logic           sign_en;
      logic           finish;
   } lct_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic sweep_last;
      logic need_math;
      logic out_busy;
   } lct_sts_type;

endpackage

### rtl/core/line_crossing_trigger.sv
// Channel   Direction  Handshake          Payload
// req_*     in         req_valid/stall    action, slot, centre_x/y, confirmed, history_count
// rsp_*     out        rsp_valid/stall    fired, cross_dir, slot_out
// csr_*     in         csr_write_enable   csr_index, csr_write_data (no read-back)
//
// An evaluated in-range item whose slot holds a stored point holds the block through states
// MUL0 to MUL3, SIGN and DONE, its result loaded in DONE: the four orientation products run
// one per cycle through a shared multiplier pair. Every other item holds it through MUL0 and
// DONE (slot memory read, then write-back).
// After reset a clearing pass over all TRACK_SLOTS slots runs with req_stall high;
// configuration writes are taken during it.
// A result waits in the output register while rsp_stall is high; the next item is
// accepted meanwhile and its write-back holds until the output register is free.
module line_crossing_trigger
   import lct_pkg::*;
#(
   parameter int TRACK_SLOTS = 64,
   parameter int COORD_BITS  = 16
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_action,
   input  logic [SLOT_BITS-1:0]       req_slot,
   input  logic [COORD_PORT_BITS-1:0] req_centre_x,
   input  logic [COORD_PORT_BITS-1:0] req_centre_y,
   input  logic                       req_confirmed,
   input  logic [HIST_BITS-1:0]       req_history_count,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_fired,
   output logic                       rsp_cross_dir,
   output logic [SLOT_BITS-1:0]       rsp_slot_out,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_write_data
);

   lct_cmd_type cmd;
   lct_sts_type sts;

   lct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lct_datapath #(
      .TRACK_SLOTS (TRACK_SLOTS),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_action        (req_action),
      .req_slot          (req_slot),
      .req_centre_x      (req_centre_x),
      .req_centre_y      (req_centre_y),
      .req_confirmed     (req_confirmed),
      .req_history_count (req_history_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fired         (rsp_fired),
      .rsp_cross_dir     (rsp_cross_dir),
      .rsp_slot_out      (rsp_slot_out),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .cmd               (cmd),
      .sts               (sts)
   );

`ifndef NO_ASSERTIONS
   // one item at a time: the cycle after an accept the input is stalled
   ap_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while previous item still in work");

   // clearing pass holds off items right after reset
   ap_sweep_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> req_stall)
      else $error("item port open before slot clearing pass");

   // write-back never overwrites a result still waiting
   ap_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !(rsp_valid && rsp_stall))
      else $error("result overwritten while stalled");

   // a new result only comes from a finished item
   ap_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.finish))
      else $error("result valid without finished item");

   // direction is reported only with a crossing
   ap_dir_with_fire: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_fired) |-> !rsp_cross_dir)
      else $error("direction set on non-firing result");
`endif

endmodule

### rtl/core/lct_ctrl.sv
module lct_ctrl
   import lct_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  lct_sts_type sts,
   output lct_cmd_type cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      cmd.sweep   = 1'b0;
      cmd.load    = 1'b0;
      cmd.mul_en  = 1'b0;
      cmd.mul_sel = ORI_AB_P;
      cmd.sign_en = 1'b0;
      cmd.finish  = 1'b0;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
            if (req_valid) begin
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            // slot entry is readable here: decide whether the geometry runs
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ORI_AB_P;
            state_in    = sts.need_math ? ST_MUL1 : ST_DONE;
         end
         ST_MUL1: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ORI_AB_Q;
            cmd.sign_en = 1'b1;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ORI_PQ_A;
            cmd.sign_en = 1'b1;
            state_in    = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = ORI_PQ_B;
            cmd.sign_en = 1'b1;
            state_in    = ST_SIGN;
         end
         ST_SIGN: begin
            cmd.sign_en = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            // wait until the output register is free
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase
   end

endmodule

### rtl/core/lct_datapath.sv
module lct_datapath
   import lct_pkg::*;
#(
   parameter int TRACK_SLOTS = 64,
   parameter int COORD_BITS  = 16
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_action,
   input  logic [SLOT_BITS-1:0]       req_slot,
   input  logic [COORD_PORT_BITS-1:0] req_centre_x,
   input  logic [COORD_PORT_BITS-1:0] req_centre_y,
   input  logic                       req_confirmed,
   input  logic [HIST_BITS-1:0]       req_history_count,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_fired,
   output logic                       rsp_cross_dir,
   output logic [SLOT_BITS-1:0]       rsp_slot_out,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_write_data,
   input  lct_cmd_type                cmd,
   output lct_sts_type                sts
);

   localparam int CW = (COORD_BITS < COORD_PORT_BITS) ? COORD_BITS : COORD_PORT_BITS;
   localparam int IW = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
   localparam int PW = 2 * CW + 2;
   localparam int WW = 2 * CW + 2;

   // Configuration registers
   logic                   line_enable_ff;
   logic [CW-1:0]          ax_ff, ay_ff, bx_ff, by_ff;
   logic [FILTER_BITS-1:0] filter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_enable_ff <= 1'b0;
         ax_ff          <= '0;
         ay_ff          <= '0;
         bx_ff          <= '0;
         by_ff          <= '0;
         filter_ff      <= FILTER_BOTH;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LINE_ENABLE:  line_enable_ff <= csr_write_data[0];
            CSR_LINE_START_X: ax_ff          <= csr_write_data[CW-1:0];
            CSR_LINE_START_Y: ay_ff          <= csr_write_data[CW-1:0];
            CSR_LINE_END_X:   bx_ff          <= csr_write_data[CW-1:0];
            CSR_LINE_END_Y:   by_ff          <= csr_write_data[CW-1:0];
            CSR_DIR_FILTER:   filter_ff      <= csr_write_data[FILTER_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Item registers, captured on accept
   logic                 act_ff;
   logic [SLOT_BITS-1:0] slot_ff;
   logic [IW-1:0]        idx_ff;
   logic                 inrange_ff;
   logic                 eval_ff;
   logic [CW-1:0]        qx_ff, qy_ff;
   logic [IW-1:0]        req_idx;
   logic                 req_inrange;
   logic                 req_eval;

   assign req_idx     = IW'(req_slot);
   assign req_inrange = LIMIT_BITS'(req_slot) < LIMIT_BITS'(TRACK_SLOTS);
   assign req_eval    = (req_action == ACT_EVAL) && line_enable_ff && req_confirmed &&
                        (req_history_count >= HIST_MIN);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff     <= req_action;
         slot_ff    <= req_slot;
         idx_ff     <= req_idx;
         inrange_ff <= req_inrange;
         eval_ff    <= req_eval;
         qx_ff      <= req_centre_x[CW-1:0];
         qy_ff      <= req_centre_y[CW-1:0];
      end
   end

   // Slot memory: {crossed, seen, last_x, last_y}
   logic [WW-1:0] slot_mem_ff [TRACK_SLOTS];
   logic [WW-1:0] rd_ff;
   logic          mem_we;
   logic [IW-1:0] mem_addr;
   logic [WW-1:0] mem_wdata;
   logic [IW-1:0] sweep_cnt_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem_ff[mem_addr] <= mem_wdata;
      end
      if (cmd.load) begin
         rd_ff <= slot_mem_ff[req_idx];
      end
   end

   // Clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_cnt_ff <= '0;
      end else if (cmd.sweep) begin
         sweep_cnt_ff <= sweep_cnt_ff + 1'b1;
      end
   end

   logic          rd_crossed, rd_seen;
   logic [CW-1:0] px, py;

   assign rd_crossed = rd_ff[WW-1];
   assign rd_seen    = rd_ff[WW-2];
   assign px         = rd_ff[2*CW-1:CW];
   assign py         = rd_ff[CW-1:0];

   // Orientation operand select: (x2-x1)*(y3-y1) - (y2-y1)*(x3-x1)
   logic [CW-1:0]        x1, y1, x2, y2, x3, y3;
   logic signed [CW:0]   dx21, dy21, dx31, dy31;
   logic signed [PW-1:0] prod_a_ff, prod_b_ff;
   orient_sel_type       prod_sel_ff;

   always_comb begin
      case (cmd.mul_sel)
         ORI_AB_P: begin x1 = ax_ff; y1 = ay_ff; x2 = bx_ff; y2 = by_ff; x3 = px;    y3 = py;    end
         ORI_AB_Q: begin x1 = ax_ff; y1 = ay_ff; x2 = bx_ff; y2 = by_ff; x3 = qx_ff; y3 = qy_ff; end
         ORI_PQ_A: begin x1 = px;    y1 = py;    x2 = qx_ff; y2 = qy_ff; x3 = ax_ff; y3 = ay_ff; end
         ORI_PQ_B: begin x1 = px;    y1 = py;    x2 = qx_ff; y2 = qy_ff; x3 = bx_ff; y3 = by_ff; end
         default:  begin x1 = ax_ff; y1 = ay_ff; x2 = bx_ff; y2 = by_ff; x3 = px;    y3 = py;    end
      endcase
   end

   assign dx21 = $signed({1'b0, x2}) - $signed({1'b0, x1});
   assign dy21 = $signed({1'b0, y2}) - $signed({1'b0, y1});
   assign dx31 = $signed({1'b0, x3}) - $signed({1'b0, x1});
   assign dy31 = $signed({1'b0, y3}) - $signed({1'b0, y1});

   // Shared multiplier pair, one orientation per cycle
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_a_ff   <= PW'(dx21) * PW'(dy31);
         prod_b_ff   <= PW'(dy21) * PW'(dx31);
         prod_sel_ff <= cmd.mul_sel;
      end
   end

   // Sign of the registered products' difference
   logic signed [PW:0] orient_val;
   logic [3:0]         pos_ff, neg_ff;

   assign orient_val = $signed({prod_a_ff[PW-1], prod_a_ff}) -
                       $signed({prod_b_ff[PW-1], prod_b_ff});

   always_ff @(posedge clock) begin
      if (cmd.sign_en) begin
         pos_ff[prod_sel_ff] <= !orient_val[PW] && (orient_val != '0);
         neg_ff[prod_sel_ff] <= orient_val[PW];
      end
   end

   // Crossing decision
   logic opp_line, opp_move, cross_dir_raw, dir_pass, fire;

   assign opp_line = (pos_ff[ORI_AB_P] && neg_ff[ORI_AB_Q]) ||
                     (neg_ff[ORI_AB_P] && pos_ff[ORI_AB_Q]);
   assign opp_move = (pos_ff[ORI_PQ_A] && neg_ff[ORI_PQ_B]) ||
                     (neg_ff[ORI_PQ_A] && pos_ff[ORI_PQ_B]);
   // with d1, d2 of opposite sign the motion cross product has the sign of d2
   assign cross_dir_raw = neg_ff[ORI_AB_Q] ? DIR_OUT : DIR_IN;
   assign dir_pass = (filter_ff == FILTER_BOTH) ||
                     ((filter_ff == FILTER_IN) && (cross_dir_raw == DIR_IN)) ||
                     ((filter_ff == FILTER_OUT) && (cross_dir_raw == DIR_OUT));
   assign fire = sts.need_math && opp_line && opp_move && !rd_crossed && dir_pass;

   // Memory write port: sweep or item write-back
   always_comb begin
      if (cmd.sweep) begin
         mem_we    = 1'b1;
         mem_addr  = sweep_cnt_ff;
         mem_wdata = '0;
      end else begin
         mem_we   = cmd.finish && inrange_ff && ((act_ff == ACT_CLEAR) || eval_ff);
         mem_addr = idx_ff;
         if (act_ff == ACT_CLEAR) begin
            mem_wdata = {1'b0, 1'b0, qx_ff, qy_ff};
         end else begin
            mem_wdata = {rd_crossed || fire, 1'b1, qx_ff, qy_ff};
         end
      end
   end

   // Output register
   logic                 rsp_valid_ff;
   logic                 rsp_fired_ff;
   logic                 rsp_dir_ff;
   logic [SLOT_BITS-1:0] rsp_slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_fired_ff <= fire;
         rsp_dir_ff   <= fire && cross_dir_raw;
         rsp_slot_ff  <= slot_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fired     = rsp_fired_ff;
   assign rsp_cross_dir = rsp_dir_ff;
   assign rsp_slot_out  = rsp_slot_ff;

   // Status
   assign sts.sweep_last = (sweep_cnt_ff == IW'(TRACK_SLOTS - 1));
   assign sts.need_math  = inrange_ff && eval_ff && rd_seen;
   assign sts.out_busy   = rsp_valid_ff && rsp_stall;

endmodule

### dv/line_crossing_trigger_tb.sv
module line_crossing_trigger_tb;
   import lct_pkg::*;

   localparam int NUM_SLOTS    = 64;
   localparam int NUM_PHASES   = 9;
   localparam int PHASE_ITEMS  = 135;
   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 200;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int COORD_MAX    = 65535;
   localparam int BOX_MARGIN   = 256;

   // Filter code that passes no direction
   localparam logic [FILTER_BITS-1:0] FILTER_NONE = 2'd3;
   // Register indexes past the end of the map
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 3'd7;

   // Directed geometry around a vertical line at x = 1000
   localparam logic [COORD_PORT_BITS-1:0] WEST_X = 16'd500;
   localparam logic [COORD_PORT_BITS-1:0] EAST_X = 16'd1500;
   localparam logic [COORD_PORT_BITS-1:0] LINE_X = 16'd1000;
   localparam logic [COORD_PORT_BITS-1:0] MID_Y  = 16'd1000;
   localparam logic [COORD_PORT_BITS-1:0] LOW_Y  = 16'd100;
   localparam logic [COORD_PORT_BITS-1:0] FAR_Y  = 16'd3000;
   localparam logic [COORD_PORT_BITS-1:0] TOP_Y  = 16'd2000;

   typedef struct packed {
      logic                       action;
      logic [SLOT_BITS-1:0]       slot;
      logic [COORD_PORT_BITS-1:0] centre_x;
      logic [COORD_PORT_BITS-1:0] centre_y;
      logic                       confirmed;
      logic [HIST_BITS-1:0]       history_count;
   } sighting_type;

   typedef struct packed {
      logic                 fired;
      logic                 cross_dir;
      logic [SLOT_BITS-1:0] slot;
   } trigger_type;

   // Typed-in outcome of a directed row, or defer to the predictor
   typedef enum logic [1:0] {
      OUTCOME_MODEL,
      OUTCOME_QUIET,
      OUTCOME_IN,
      OUTCOME_OUT
   } outcome_type;

   typedef struct packed {
      logic                      is_write;
      logic [CSR_INDEX_BITS-1:0] csr_index;
      logic [CSR_DATA_BITS-1:0]  csr_data;
      sighting_type              sighting;
      outcome_type               outcome;
   } step_type;

   // Block ports
   logic                       clock;
   logic                       reset             = 1'b1;
   logic                       req_valid         = 1'b0;
   logic                       req_stall;
   logic                       req_action        = ACT_EVAL;
   logic [SLOT_BITS-1:0]       req_slot          = '0;
   logic [COORD_PORT_BITS-1:0] req_centre_x      = '0;
   logic [COORD_PORT_BITS-1:0] req_centre_y      = '0;
   logic                       req_confirmed     = 1'b0;
   logic [HIST_BITS-1:0]       req_history_count = '0;
   logic                       rsp_valid;
   logic                       rsp_stall         = 1'b0;
   logic                       rsp_fired;
   logic                       rsp_cross_dir;
   logic [SLOT_BITS-1:0]       rsp_slot_out;
   logic                       csr_write_enable  = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index         = CSR_LINE_ENABLE;
   logic [CSR_DATA_BITS-1:0]   csr_write_data    = '0;

   // Shadow of the tripwire state and registers
   logic                       seen_flags    [NUM_SLOTS];
   logic                       crossed_flags [NUM_SLOTS];
   logic [COORD_PORT_BITS-1:0] last_x        [NUM_SLOTS];
   logic [COORD_PORT_BITS-1:0] last_y        [NUM_SLOTS];
   logic                       cfg_enable   = 1'b0;
   logic [COORD_PORT_BITS-1:0] cfg_start_x  = '0;
   logic [COORD_PORT_BITS-1:0] cfg_start_y  = '0;
   logic [COORD_PORT_BITS-1:0] cfg_end_x    = '0;
   logic [COORD_PORT_BITS-1:0] cfg_end_y    = '0;
   logic [FILTER_BITS-1:0]     cfg_filter   = FILTER_BOTH;

   trigger_type pending_triggers [$];
   trigger_type oldest_trigger;
   step_type    directed_plan [$];

   int mismatches      = 0;
   int results_checked = 0;
   int sightings_sent  = 0;
   int triggers_in     = 0;
   int triggers_out    = 0;
   int cycle_count     = 0;
   int sender_idle_pct = 0;
   int recv_stall_pct  = 0;
   int hold_count      = 0;
   int hold_taken      = 0;
   int hold_left       = 0;

   line_crossing_trigger i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_slot          (req_slot),
      .req_centre_x      (req_centre_x),
      .req_centre_y      (req_centre_y),
      .req_confirmed     (req_confirmed),
      .req_history_count (req_history_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_fired         (rsp_fired),
      .rsp_cross_dir     (rsp_cross_dir),
      .rsp_slot_out      (rsp_slot_out),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[line_crossing_trigger] ERROR");
         $finish;
      end
   end

   // Side of point 3 relative to the directed segment 1->2
   function automatic longint orient(input longint x1, y1, x2, y2, x3, y3);
      return (x2 - x1) * (y3 - y1) - (y2 - y1) * (x3 - x1);
   endfunction

   function automatic bit opposite_signs(input longint a, b);
      return (a > 0 && b < 0) || (a < 0 && b > 0);
   endfunction

   // Trigger decision for one sighting; updates the shadow slot state
   function automatic trigger_type predict_trigger(input sighting_type s);
      trigger_type t;
      longint      ax, ay, bx, by, px, py, qx, qy, motion;
      logic        heading;
      t.fired     = 1'b0;
      t.cross_dir = DIR_IN;
      t.slot      = s.slot;
      if (s.action == ACT_CLEAR) begin
         seen_flags[s.slot]    = 1'b0;
         crossed_flags[s.slot] = 1'b0;
      end else if (cfg_enable && s.confirmed && s.history_count >= HIST_MIN) begin
         if (!seen_flags[s.slot]) begin
            seen_flags[s.slot] = 1'b1;
         end else begin
            ax = longint'(cfg_start_x);
            ay = longint'(cfg_start_y);
            bx = longint'(cfg_end_x);
            by = longint'(cfg_end_y);
            px = longint'(last_x[s.slot]);
            py = longint'(last_y[s.slot]);
            qx = longint'(s.centre_x);
            qy = longint'(s.centre_y);
            // strict crossing: both pairs of orientations have opposite signs
            if (opposite_signs(orient(ax, ay, bx, by, px, py),
                               orient(ax, ay, bx, by, qx, qy)) &&
                opposite_signs(orient(px, py, qx, qy, ax, ay),
                               orient(px, py, qx, qy, bx, by)) &&
                !crossed_flags[s.slot]) begin
               motion  = (bx - ax) * (qy - py) - (by - ay) * (qx - px);
               heading = (motion > 0) ? DIR_IN : DIR_OUT;
               if (cfg_filter == FILTER_BOTH ||
                   (cfg_filter == FILTER_IN && heading == DIR_IN) ||
                   (cfg_filter == FILTER_OUT && heading == DIR_OUT)) begin
                  t.fired               = 1'b1;
                  t.cross_dir           = heading;
                  crossed_flags[s.slot] = 1'b1;
               end
            end
         end
         last_x[s.slot] = s.centre_x;
         last_y[s.slot] = s.centre_y;
      end
      return t;
   endfunction

   function automatic step_type sight_step(input logic action, input int slot,
                                           input logic [COORD_PORT_BITS-1:0] x, y,
                                           input logic confirmed, input int hist,
                                           input outcome_type outcome);
      step_type st;
      st                        = '0;
      st.sighting.action        = action;
      st.sighting.slot          = SLOT_BITS'(slot);
      st.sighting.centre_x      = x;
      st.sighting.centre_y      = y;
      st.sighting.confirmed     = confirmed;
      st.sighting.history_count = HIST_BITS'(hist);
      st.outcome                = outcome;
      return st;
   endfunction

   function automatic step_type csr_step(input logic [CSR_INDEX_BITS-1:0] idx,
                                         input logic [CSR_DATA_BITS-1:0] data);
      step_type st;
      st           = '0;
      st.is_write  = 1'b1;
      st.csr_index = idx;
      st.csr_data  = data;
      st.outcome   = OUTCOME_MODEL;
      return st;
   endfunction

   // Random sighting, mostly ready tracks on few slots near the line
   function automatic sighting_type random_sighting();
      sighting_type s;
      int           roll, lo_x, hi_x, lo_y, hi_y;
      roll = $urandom_range(99);
      lo_x = (cfg_start_x < cfg_end_x) ? int'(cfg_start_x) : int'(cfg_end_x);
      hi_x = (cfg_start_x < cfg_end_x) ? int'(cfg_end_x) : int'(cfg_start_x);
      lo_y = (cfg_start_y < cfg_end_y) ? int'(cfg_start_y) : int'(cfg_end_y);
      hi_y = (cfg_start_y < cfg_end_y) ? int'(cfg_end_y) : int'(cfg_start_y);
      lo_x = (lo_x > BOX_MARGIN) ? lo_x - BOX_MARGIN : 0;
      lo_y = (lo_y > BOX_MARGIN) ? lo_y - BOX_MARGIN : 0;
      hi_x = (hi_x + BOX_MARGIN > COORD_MAX) ? COORD_MAX : hi_x + BOX_MARGIN;
      hi_y = (hi_y + BOX_MARGIN > COORD_MAX) ? COORD_MAX : hi_y + BOX_MARGIN;
      s.action        = (roll < 5) ? ACT_CLEAR : ACT_EVAL;
      s.slot          = ($urandom_range(3) != 0) ? SLOT_BITS'($urandom_range(7))
                                                 : SLOT_BITS'($urandom_range(63));
      s.confirmed     = (roll >= 5 && roll < 10) ? 1'b0 : 1'b1;
      s.history_count = (roll >= 10 && roll < 15) ? HIST_BITS'($urandom_range(1))
                                                  : HIST_BITS'($urandom_range(255, 2));
      if (roll < 5)
         s.confirmed = 1'(($urandom_range(1)));
      if (roll >= 90) begin
         s.centre_x = COORD_PORT_BITS'($urandom_range(COORD_MAX));
         s.centre_y = COORD_PORT_BITS'($urandom_range(COORD_MAX));
      end else if (roll >= 85) begin
         // sit exactly on a line end point
         s.centre_x = $urandom_range(1) ? cfg_start_x : cfg_end_x;
         s.centre_y = (s.centre_x == cfg_start_x) ? cfg_start_y : cfg_end_y;
      end else begin
         s.centre_x = COORD_PORT_BITS'($urandom_range(hi_x, lo_x));
         s.centre_y = COORD_PORT_BITS'($urandom_range(hi_y, lo_y));
      end
      return s;
   endfunction

   // Present one item and hold it until accepted
   task automatic send_sighting(input sighting_type s, input outcome_type outcome);
      trigger_type t;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_action        <= s.action;
      req_slot          <= s.slot;
      req_centre_x      <= s.centre_x;
      req_centre_y      <= s.centre_y;
      req_confirmed     <= s.confirmed;
      req_history_count <= s.history_count;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      t = predict_trigger(s);
      case (outcome)
         OUTCOME_QUIET: begin
            t.fired     = 1'b0;
            t.cross_dir = DIR_IN;
         end
         OUTCOME_IN: begin
            t.fired     = 1'b1;
            t.cross_dir = DIR_IN;
         end
         OUTCOME_OUT: begin
            t.fired     = 1'b1;
            t.cross_dir = DIR_OUT;
         end
         default: ;
      endcase
      pending_triggers.push_back(t);
      sightings_sent++;
   endtask

   // Register write once the block has gone quiet
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      req_valid <= 1'b0;
      while (pending_triggers.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_LINE_ENABLE:  cfg_enable  = data[0];
         CSR_LINE_START_X: cfg_start_x = data;
         CSR_LINE_START_Y: cfg_start_y = data;
         CSR_LINE_END_X:   cfg_end_x   = data;
         CSR_LINE_END_Y:   cfg_end_y   = data;
         CSR_DIR_FILTER:   cfg_filter  = data[FILTER_BITS-1:0];
         default: ;
      endcase
   endtask

   // Result checker and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_triggers.size() == 0) begin
            $display("%0t: result with nothing expected: fired %0d dir %0d slot %0d",
                     $time, rsp_fired, rsp_cross_dir, rsp_slot_out);
            mismatches++;
         end else begin
            oldest_trigger = pending_triggers.pop_front();
            results_checked++;
            if (rsp_fired !== oldest_trigger.fired) begin
               $display("%0t: fired expected %0d actual %0d", $time,
                        oldest_trigger.fired, rsp_fired);
               mismatches++;
            end
            if (rsp_cross_dir !== oldest_trigger.cross_dir) begin
               $display("%0t: cross_dir expected %0d actual %0d", $time,
                        oldest_trigger.cross_dir, rsp_cross_dir);
               mismatches++;
            end
            if (rsp_slot_out !== oldest_trigger.slot) begin
               $display("%0t: slot_out expected %0d actual %0d", $time,
                        oldest_trigger.slot, rsp_slot_out);
               mismatches++;
            end
            if (rsp_fired === 1'b1 && rsp_cross_dir === DIR_IN)
               triggers_in++;
            else if (rsp_fired === 1'b1)
               triggers_out++;
         end
      end
      // long hold-off on request, otherwise random stalls
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_count != hold_taken) begin
         rsp_stall  <= 1'b1;
         hold_taken <= hold_count;
         hold_left  <= HOLD_CYCLES;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Stimulus
   initial begin
      int                      phase, n, phase_items, start_x, start_y, end_x, end_y;
      logic [FILTER_BITS-1:0]  filter_code;
      logic                    line_on;

      foreach (seen_flags[i]) begin
         seen_flags[i]    = 1'b0;
         crossed_flags[i] = 1'b0;
         last_x[i]        = '0;
         last_y[i]        = '0;
      end

      // Directed rows, line x = 1000 from y = 0 to 2000 once configured
      directed_plan.push_back(sight_step(ACT_EVAL, 0, WEST_X, MID_Y, 1'b1, 2, OUTCOME_QUIET));
      directed_plan.push_back(csr_step(CSR_LINE_START_X, LINE_X));
      directed_plan.push_back(csr_step(CSR_LINE_START_Y, 16'd0));
      directed_plan.push_back(csr_step(CSR_LINE_END_X, LINE_X));
      directed_plan.push_back(csr_step(CSR_LINE_END_Y, TOP_Y));
      directed_plan.push_back(csr_step(CSR_LINE_ENABLE, 16'd1));
      directed_plan.push_back(csr_step(CSR_DIR_FILTER, CSR_DATA_BITS'(FILTER_BOTH)));
      directed_plan.push_back(csr_step(CSR_SPARE_A, 16'hFFFF));
      directed_plan.push_back(csr_step(CSR_SPARE_B, 16'h5A5A));
      // first sighting, cross east, cross back (already fired), clear, refire west
      directed_plan.push_back(sight_step(ACT_EVAL, 0, WEST_X, MID_Y, 1'b1, 2, OUTCOME_QUIET));
      directed_plan.push_back(sight_step(ACT_EVAL, 0, EAST_X, MID_Y, 1'b1, 2, OUTCOME_OUT));
      directed_plan.push_back(sight_step(ACT_EVAL, 0, WEST_X, MID_Y, 1'b1, 9, OUTCOME_QUIET));
      directed_plan.push_back(sight_step(ACT_CLEAR, 0, 16'hFFFF, 16'hFFFF, 1'b0, 0,
                                         OUTCOME_QUIET));
      directed_plan.push_back(sight_step(ACT_EVAL, 0, EAST_X, MID_Y, 1'b1, 255, OUTCOME_MODEL));
      directed_plan.push_back(sight_step(ACT_EVAL, 0, WEST_X, MID_Y, 1'b1, 2, OUTCOME_IN));
      // track not ready: unconfirmed, then short history
      directed_plan.push_back(sight_step(ACT_EVAL, 1, WEST_X, MID_Y, 1'b0, 255, OUTCOME_QUIET));
      directed_plan.push_back(sight_step(ACT_EVAL, 1, EAST_X, MID_Y, 1'b1, 1, OUTCOME_QUIET));
      directed_plan.push_back(sight_step(ACT_EVAL, 1, WEST_X, MID_Y, 1'b1, 2, OUTCOME_MODEL));
      directed_plan.push_back(sight_step(ACT_EVAL, 1, EAST_X, MID_Y, 1'b1, 2, OUTCOME_OUT));
      // coordinate extremes on the top slot
      directed_plan.push_back(sight_step(ACT_EVAL, 63, 16'd0, 16'd0, 1'b1, 255, OUTCOME_QUIET));
      directed_plan.push_back(sight_step(ACT_EVAL, 63, 16'hFFFF, 16'hFFFF, 1'b1, 255,
                                         OUTCOME_OUT));
      // starting on the line, and passing beyond its end, never count
      directed_plan.push_back(sight_step(ACT_EVAL, 2, LINE_X, 16'd500, 1'b1, 3, OUTCOME_QUIET));
      directed_plan.push_back(sight_step(ACT_EVAL, 2, EAST_X, 16'd500, 1'b1, 3, OUTCOME_QUIET));
      directed_plan.push_back(sight_step(ACT_EVAL, 3, WEST_X, FAR_Y, 1'b1, 3, OUTCOME_QUIET));
      directed_plan.push_back(sight_step(ACT_EVAL, 3, EAST_X, FAR_Y, 1'b1, 3, OUTCOME_QUIET));
      // inbound-only filter blocks the outbound move, then passes inbound
      directed_plan.push_back(csr_step(CSR_DIR_FILTER, CSR_DATA_BITS'(FILTER_IN)));
      directed_plan.push_back(sight_step(ACT_EVAL, 4, WEST_X, LOW_Y, 1'b1, 4, OUTCOME_QUIET));
      directed_plan.push_back(sight_step(ACT_EVAL, 4, EAST_X, LOW_Y, 1'b1, 4, OUTCOME_QUIET));
      directed_plan.push_back(sight_step(ACT_EVAL, 4, WEST_X, LOW_Y, 1'b1, 4, OUTCOME_IN));
      // reserved filter passes nothing
      directed_plan.push_back(csr_step(CSR_DIR_FILTER, CSR_DATA_BITS'(FILTER_NONE)));
      directed_plan.push_back(sight_step(ACT_EVAL, 5, WEST_X, LOW_Y, 1'b1, 5, OUTCOME_QUIET));
      directed_plan.push_back(sight_step(ACT_EVAL, 5, EAST_X, LOW_Y, 1'b1, 5, OUTCOME_QUIET));
      // degenerate line: end equals start
      directed_plan.push_back(csr_step(CSR_DIR_FILTER, CSR_DATA_BITS'(FILTER_OUT)));
      directed_plan.push_back(csr_step(CSR_LINE_END_Y, 16'd0));
      directed_plan.push_back(sight_step(ACT_EVAL, 5, WEST_X, LOW_Y, 1'b1, 5, OUTCOME_QUIET));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].is_write)
            write_csr(directed_plan[i].csr_index, directed_plan[i].csr_data);
         else
            send_sighting(directed_plan[i].sighting, directed_plan[i].outcome);
      end

      // Random phases, one line setting each
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         start_x     = $urandom_range(COORD_MAX);
         start_y     = $urandom_range(COORD_MAX);
         end_x       = $urandom_range(COORD_MAX);
         end_y       = $urandom_range(COORD_MAX);
         filter_code = FILTER_BITS'($urandom_range(3));
         line_on     = 1'b1;
         phase_items = PHASE_ITEMS;
         case (phase)
            0: begin
               start_x = 0; start_y = 0; end_x = COORD_MAX; end_y = COORD_MAX;
               filter_code = FILTER_BOTH;
            end
            1: begin
               start_x = 0; start_y = COORD_MAX; end_x = COORD_MAX; end_y = 0;
               filter_code = FILTER_IN;
            end
            2: filter_code = FILTER_OUT;
            3: filter_code = FILTER_NONE;
            4: begin
               line_on     = 1'b0;
               phase_items = 60;
            end
            default: ;
         endcase
         write_csr(CSR_LINE_START_X, CSR_DATA_BITS'(start_x));
         write_csr(CSR_LINE_START_Y, CSR_DATA_BITS'(start_y));
         write_csr(CSR_LINE_END_X, CSR_DATA_BITS'(end_x));
         write_csr(CSR_LINE_END_Y, CSR_DATA_BITS'(end_y));
         // upper data bits are noise the block must mask off
         write_csr(CSR_DIR_FILTER, CSR_DATA_BITS'({$urandom_range(16383), filter_code}));
         write_csr(CSR_LINE_ENABLE, CSR_DATA_BITS'({$urandom_range(32767), line_on}));

         case (phase % 4)
            0: begin sender_idle_pct = 0;  recv_stall_pct <= 0;  end
            1: begin sender_idle_pct = 67; recv_stall_pct <= 0;  end
            2: begin sender_idle_pct = 0;  recv_stall_pct <= 67; end
            default: begin sender_idle_pct = 19; recv_stall_pct <= 19; end
         endcase
         // back the block up against a long receiver hold-off
         if (phase == 0 || phase == 8)
            hold_count <= hold_count + 1;

         for (n = 0; n < phase_items; n++)
            send_sighting(random_sighting(), OUTCOME_MODEL);
      end

      req_valid <= 1'b0;
      while (pending_triggers.size() != 0)
         @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d results from %0d items over %0d random line settings.",
               results_checked, sightings_sent, NUM_PHASES);
      $display("Crossings fired: %0d inbound, %0d outbound; %0d mismatches.",
               triggers_in, triggers_out, mismatches);
      if (mismatches == 0)
         $display("[line_crossing_trigger] OK");
      else
         $display("[line_crossing_trigger] ERROR");
      $finish;
   end

endmodule
